/* rtl/sample_truncate_saturate_packer_macros.svh */
// Assertion macros for the sample packer.
`ifndef SAMPLE_TRUNCATE_SATURATE_PACKER_MACROS_SVH
`define SAMPLE_TRUNCATE_SATURATE_PACKER_MACROS_SVH

// same-cycle implication
`define STP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stp check failed");

// next-cycle implication
`define STP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stp check failed");

`endif

/* rtl/stp_pkg.sv */
// Shared control type, constants and saturation function of the sample packer.
package stp_pkg;

   localparam int SAMPLE_BITS_DEF = 32;
   localparam int WORD_BITS       = 32;
   localparam int BYTE_BITS       = 8;
   localparam int AXES            = 3;
   localparam int AXIS_BITS       = $clog2(AXES);
   localparam logic [7:0] MAX_WIDTH = 8'd4;
   localparam logic [7:0] MAX_SHIFT = 8'd31;

   typedef struct packed {
      logic [2:0] width;
      logic [4:0] shift;
      logic       fin;
      logic       err;
   } stp_ctl_type;

   // clamp to the signed range of w bytes
   function automatic logic signed [WORD_BITS-1:0] sat_word(
      input logic signed [WORD_BITS-1:0] v,
      input logic [2:0]                  w);
      logic [4:0]                  k;
      logic signed [WORD_BITS-1:0] hi;
      logic signed [WORD_BITS-1:0] ones;
      k    = 5'(BYTE_BITS * int'(w) - 1);
      ones = '1;
      hi   = v >>> k;
      if (hi == '0 || hi == ones) begin
         sat_word = v;
      end else if (v[WORD_BITS-1]) begin
         sat_word = ones << k;
      end else begin
         sat_word = ~(ones << k);
      end
   endfunction

endpackage

/* rtl/stp_front.sv */
// Input capture, field check, then arithmetic shift and round-toward-zero flag.
module stp_front import stp_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [AXES-1:0][SAMPLE_BITS-1:0]    in_samp,
   input  logic [7:0]                          in_width,
   input  logic [7:0]                          in_shift,
   input  logic                                in_fin,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [AXES-1:0][SAMPLE_BITS-1:0]    out_quot,
   output logic [AXES-1:0]                     out_inc,
   output stp_ctl_type                         out_ctl
);

   logic                             v1_ff, v1_in, v2_ff, v2_in;
   logic                             r1, r2;
   logic [AXES-1:0][SAMPLE_BITS-1:0] samp_ff;
   stp_ctl_type                      ctl1_ff, ctl1_in, ctl2_ff;
   logic [AXES-1:0][SAMPLE_BITS-1:0] quot_ff, quot_in;
   logic [AXES-1:0]                  inc_ff, inc_in;
   logic [SAMPLE_BITS-1:0]           mask;

   assign r2       = !v2_ff || out_ready;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_comb begin
      v1_in = v1_ff;
      if (r1) begin
         v1_in = in_valid;
      end
      v2_in = v2_ff;
      if (r2) begin
         v2_in = v1_ff;
      end
   end

   always_comb begin
      ctl1_in.width = in_width[2:0];
      ctl1_in.shift = in_shift[4:0];
      ctl1_in.fin   = in_fin;
      ctl1_in.err   = (in_width == '0) || (in_width > MAX_WIDTH) || (in_shift > MAX_SHIFT);
   end

   always_comb begin
      mask = ~({SAMPLE_BITS{1'b1}} << ctl1_ff.shift);
      for (int a = 0; a < AXES; a++) begin
         quot_in[a] = $signed(samp_ff[a]) >>> ctl1_ff.shift;
         inc_in[a]  = samp_ff[a][SAMPLE_BITS-1] && |(samp_ff[a] & mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (r1 && in_valid) begin
         samp_ff <= in_samp;
         ctl1_ff <= ctl1_in;
      end
      if (r2 && v1_ff) begin
         quot_ff <= quot_in;
         inc_ff  <= inc_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_quot  = quot_ff;
   assign out_inc   = inc_ff;
   assign out_ctl   = ctl2_ff;

endmodule

/* rtl/stp_sat.sv */
// Round-up add and saturation to the selected byte width.
module stp_sat import stp_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [AXES-1:0][SAMPLE_BITS-1:0]  in_quot,
   input  logic [AXES-1:0]                   in_inc,
   input  stp_ctl_type                       in_ctl,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [AXES-1:0][WORD_BITS-1:0]    out_word,
   output stp_ctl_type                       out_ctl
);

   logic                             v_ff, v_in;
   logic [AXES-1:0][WORD_BITS-1:0]   word_ff, word_in;
   stp_ctl_type                      ctl_ff;
   logic signed [SAMPLE_BITS-1:0]    sum [AXES];

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      v_in = v_ff;
      if (in_ready) begin
         v_in = in_valid;
      end
      for (int a = 0; a < AXES; a++) begin
         sum[a]     = $signed(in_quot[a] + SAMPLE_BITS'(in_inc[a]));
         word_in[a] = sat_word(WORD_BITS'(sum[a]), in_ctl.width);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
         ctl_ff  <= in_ctl;
      end
   end

   assign out_valid = v_ff;
   assign out_word  = word_ff;
   assign out_ctl   = ctl_ff;

endmodule

/* rtl/stp_serial.sv */
// Byte serializer: emits each axis most significant byte first.
module stp_serial import stp_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [AXES-1:0][WORD_BITS-1:0]  in_word,
   input  stp_ctl_type                     in_ctl,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [BYTE_BITS-1:0]            out_byte,
   output logic                            out_last,
   output logic                            out_eop,
   output logic                            out_err
);

   logic                           v_ff, v_in;
   logic [AXES-1:0][WORD_BITS-1:0] word_ff;
   stp_ctl_type                    ctl_ff;
   logic [AXIS_BITS-1:0]           axis_ff, axis_in;
   logic [1:0]                     bidx_ff, bidx_in;
   logic [1:0]                     top_b, pos;
   logic                           wlast, last, load;
   logic [WORD_BITS-1:0]           cur;

   assign top_b    = 2'(ctl_ff.width - 3'd1);
   assign wlast    = bidx_ff == top_b;
   assign last     = ctl_ff.err || (axis_ff == AXIS_BITS'(AXES - 1) && wlast);
   assign in_ready = !v_ff || (out_ready && last);
   assign load     = in_ready && in_valid;
   assign pos      = top_b - bidx_ff;
   assign cur      = word_ff[axis_ff];

   always_comb begin
      v_in    = v_ff;
      axis_in = axis_ff;
      bidx_in = bidx_ff;
      if (load) begin
         v_in    = 1'b1;
         axis_in = '0;
         bidx_in = '0;
      end else if (v_ff && out_ready) begin
         if (last) begin
            v_in = 1'b0;
         end else if (wlast) begin
            axis_in = axis_ff + AXIS_BITS'(1);
            bidx_in = '0;
         end else begin
            bidx_in = bidx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= 1'b0;
         axis_ff <= '0;
         bidx_ff <= '0;
      end else begin
         v_ff    <= v_in;
         axis_ff <= axis_in;
         bidx_ff <= bidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= in_word;
         ctl_ff  <= in_ctl;
      end
   end

   assign out_valid = v_ff;
   assign out_byte  = ctl_ff.err ? '0 : cur[pos*BYTE_BITS +: BYTE_BITS];
   assign out_last  = last;
   assign out_eop   = last && ctl_ff.fin;
   assign out_err   = ctl_ff.err;

endmodule

/* rtl/sample_truncate_saturate_packer.sv */
// Top level of the saturating big-endian sample packer.
//
//  channel  dir  handshake             payload
//  req      in   req_tvalid/tready     tdata: x, y, z, width, shift; tlast: packet end
//  rsp      out  rsp_tvalid/tready     tdata: byte; tuser: item end, error; tlast: packet end
//
// Four register stages: capture and check, shift, round and saturate, byte serializer.
// The first word of an item leaves after the capture, shift, saturate and serializer registers.
// The serializer sets the sustained rate: it emits 3 * width words per item (3 to 12), one word for a rejected
// item, at one word per cycle while rsp_tready is high, and takes the next item as the last word leaves.
// Synchronous reset clears the valid bits and the serializer counters; a stalled word
// holds while the stages in front keep filling.
module sample_truncate_saturate_packer import stp_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // sample_x, sample_y, sample_z, byte_width, shift_count
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // data_byte
   output logic [1:0]   rsp_tuser,   // last_of_item, field_error
   output logic         rsp_tlast
);

   logic [AXES-1:0][SAMPLE_BITS-1:0] samp, quot;
   logic [AXES-1:0]                  inc;
   logic [AXES-1:0][WORD_BITS-1:0]   word;
   stp_ctl_type                      f_ctl, s_ctl;
   logic                             f_valid, f_ready, s_valid, s_ready;
   logic                             last, err;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         samp[a] = req_tdata[a*WORD_BITS +: SAMPLE_BITS];
      end
   end

   stp_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_samp   (samp),
      .in_width  (req_tdata[103:96]),
      .in_shift  (req_tdata[111:104]),
      .in_fin    (req_tlast),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_quot  (quot),
      .out_inc   (inc),
      .out_ctl   (f_ctl)
   );

   stp_sat #(.SAMPLE_BITS(SAMPLE_BITS)) u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_quot   (quot),
      .in_inc    (inc),
      .in_ctl    (f_ctl),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_word  (word),
      .out_ctl   (s_ctl)
   );

   stp_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_word   (word),
      .in_ctl    (s_ctl),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (last),
      .out_eop   (rsp_tlast),
      .out_err   (err)
   );

   assign rsp_tuser = {err, last};

`include "sample_truncate_saturate_packer_macros.svh"

   `STP_ASSERT_NOW(a_err_word, clock, reset, rsp_tvalid && err, rsp_tdata == 8'd0 && last)
   `STP_ASSERT_NOW(a_eop_last, clock, reset, rsp_tvalid && rsp_tlast, last)
   `STP_ASSERT_NEXT(a_item_runs, clock, reset, rsp_tvalid && rsp_tready && !last, rsp_tvalid)

endmodule

/* tb/sv/tb.sv */
// Testbench for sample_truncate_saturate_packer: predicts packed bytes and checks every word.
module tb;
   import stp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500_000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       item_end;
      logic       pkt_end;
      logic       field_error;
   } out_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;   // sample_x, sample_y, sample_z, byte_width, shift_count
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;        // data_byte
   logic [1:0]   rsp_tuser;        // last_of_item, field_error
   logic         rsp_tlast;

   out_word_type expected_words[$];
   int           errors = 0;
   int           items_sent = 0;
   int           items_rejected = 0;
   int           words_checked = 0;
   int           cycles = 0;
   bit           src_idle_on = 1'b0;
   bit           sink_idle_on = 1'b0;
   int           hold_request = 0;

   sample_truncate_saturate_packer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("sample_truncate_saturate_packer: mismatch");
         $finish;
      end
   end

   // expected bytes of one sample: one error word if rejected, else shift toward zero, clamp, emit big-endian per axis
   function automatic void pack_sample(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] z, input logic [7:0] width,
                                       input logic [7:0] shift, input logic fin);
      logic [31:0]  axis [3];
      longint       v;
      longint       vmax;
      longint       vmin;
      int           wi;
      int           total;
      int           n;
      out_word_type w;
      axis = '{x, y, z};
      if (width < 8'd1 || width > MAX_WIDTH || shift > MAX_SHIFT) begin
         w = '{data_byte: 8'h00, item_end: 1'b1, pkt_end: fin, field_error: 1'b1};
         expected_words.push_back(w);
         items_rejected++;
         return;
      end
      wi    = int'(width);
      vmax  = (longint'(1) << (8 * wi - 1)) - 1;
      vmin  = -vmax - 1;
      total = AXES * wi;
      n     = 0;
      for (int a = 0; a < AXES; a++) begin
         v = longint'($signed(axis[a])) / (longint'(1) << shift);
         if (v > vmax) begin
            v = vmax;
         end else if (v < vmin) begin
            v = vmin;
         end
         for (int b = 0; b < wi; b++) begin
            w.data_byte   = 8'(v >>> (8 * (wi - 1 - b)));
            w.item_end    = (n == total - 1);
            w.pkt_end     = (n == total - 1) && fin;
            w.field_error = 1'b0;
            expected_words.push_back(w);
            n++;
         end
      end
   endfunction

   task automatic send_sample(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [7:0] width,
                              input logic [7:0] shift, input logic fin);
      int gap;
      if (src_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {shift, width, z, y, x};
      req_tlast  <= fin;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      pack_sample(x, y, z, width, shift, fin);
      items_sent++;
   endtask

   // output side: random stalls, plus a long hold when one is requested
   initial begin
      int span;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            span = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (span - 1) @(negedge clock);
         end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            span = $urandom_range(1, 12);
            rsp_tready <= 1'b0;
            repeat (span - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      out_word_type w;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: data_byte %0h tuser %0b tlast %0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            w = expected_words.pop_front();
            words_checked++;
            if (rsp_tdata !== w.data_byte) begin
               $error("data_byte: expected %0h, got %0h", w.data_byte, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[0] !== w.item_end) begin
               $error("last_of_item: expected %0b, got %0b", w.item_end, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[1] !== w.field_error) begin
               $error("field_error: expected %0b, got %0b", w.field_error, rsp_tuser[1]);
               errors++;
            end
            if (rsp_tlast !== w.pkt_end) begin
               $error("end_of_packet: expected %0b, got %0b", w.pkt_end, rsp_tlast);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] random_axis();
      case ($urandom_range(0, 5))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'($signed($urandom_range(0, 511)) - 256);
         3:       return 32'($signed($urandom_range(0, 131071)) - 65536);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random_sample();
      logic [7:0] width;
      logic [7:0] shift;
      width = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(1, 4))
            : (($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(5, 255)));
      shift = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 31))
            : 8'($urandom_range(32, 255));
      send_sample(random_axis(), random_axis(), random_axis(), width, shift,
                  1'($urandom_range(0, 3) == 0));
   endtask

   task automatic test_directed();
      send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 8'd4, 8'd0, 1'b0);
      send_sample(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 8'd1, 8'd0, 1'b0);
      send_sample(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 8'd2, 8'd0, 1'b1);
      send_sample(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 8'd3, 8'd0, 1'b0);
      // negative values round toward zero
      send_sample(32'hffff_ffff, 32'hffff_fffd, 32'hffff_fffb, 8'd1, 8'd1, 1'b0);
      send_sample(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 8'd4, 8'd31, 1'b1);
      send_sample(32'h1234_5678, 32'h8765_4321, 32'h0000_ff80, 8'd2, 8'd4, 1'b0);
      // one past each range edge, and the edges themselves
      send_sample(32'h0000_0080, 32'hffff_ff7f, 32'h0000_007f, 8'd1, 8'd0, 1'b0);
      send_sample(32'h0000_8000, 32'hffff_7fff, 32'hffff_8000, 8'd2, 8'd0, 1'b1);
      send_sample(32'h0080_0000, 32'hff7f_ffff, 32'h007f_ffff, 8'd3, 8'd0, 1'b0);
      send_sample(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 8'd4, 8'd7, 1'b1);
      send_sample(32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001, 8'd2, 8'd31, 1'b0);
      // rejected width or shift
      send_sample(32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000, 8'd0, 8'd0, 1'b0);
      send_sample(32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000, 8'd5, 8'd3, 1'b1);
      send_sample(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 8'd255, 8'd0, 1'b0);
      send_sample(32'h0000_1234, 32'h0000_0000, 32'h0000_0000, 8'd4, 8'd32, 1'b1);
      send_sample(32'h0000_1234, 32'h0000_0000, 32'h0000_0000, 8'd1, 8'd255, 1'b0);
      send_sample(32'h0000_1234, 32'h0000_0000, 32'h0000_0000, 8'd128, 8'd64, 1'b1);
      send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd1, 8'd0, 1'b1);
   endtask

   task automatic test_random_mix(input int count);
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
      repeat (count) send_random_sample();
   endtask

   task automatic test_output_hold(input int count);
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      hold_request = 300;
      repeat (count) send_random_sample();
   endtask

   task automatic test_full_rate(input int count);
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      repeat (count) send_random_sample();
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix(150);
      test_output_hold(40);
      test_random_mix(190);
      test_full_rate(70);
      drain();
      if (expected_words.size() != 0) begin
         $error("%0d expected words never arrived", expected_words.size());
         errors++;
      end
      $display("Run covered %0d samples (%0d rejected), %0d output words checked,",
               items_sent, items_rejected, words_checked);
      $display("with random stalls on both sides, one long output hold and a full-rate tail.");
      if (errors == 0) begin
         $display("sample_truncate_saturate_packer: match");
      end else begin
         $display("sample_truncate_saturate_packer: mismatch");
      end
      $finish;
   end

endmodule
